[sv/mains_voltage_frequency_monitor_macros.svh]
// ----------------------------------------------------------------------------
// Mains voltage and frequency monitor assertion macros
// Short forms for the concurrent checks of the monitor's port behavior.
// ----------------------------------------------------------------------------
`ifndef MAINS_VOLTAGE_FREQUENCY_MONITOR_MACROS_SVH
`define MAINS_VOLTAGE_FREQUENCY_MONITOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MVFM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mvfm check failed");

// The consequent holds in the cycle after the antecedent.
`define MVFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mvfm check failed");

`endif

[sv/mvfm_pkg.sv]
// ----------------------------------------------------------------------------
// mvfm_pkg
// Types, calibration constants and helpers of the mains monitor.
// ----------------------------------------------------------------------------
package mvfm_pkg;

  typedef enum logic [1:0] {
    KIND_VOLTAGE = 2'd0,
    KIND_FREQ    = 2'd1,
    KIND_RETRY   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FREQ_UNKNOWN = 2'd0,
    FREQ_50      = 2'd1,
    FREQ_60      = 2'd2
  } freq_e;

  localparam int SampleW = 10;
  localparam int StampW  = 16;
  localparam int SumW    = 16;
  localparam int VoltW   = 9;
  localparam int PeriodW = 7;
  localparam int CalW    = 12;
  localparam int ProdW   = 24;
  localparam int Volt10W = 13;
  localparam int MagW    = 21;

  // Stamp difference windows, both bounds exclusive.
  localparam logic [StampW-1:0] DIFF_60_LO = 16'd35;
  localparam logic [StampW-1:0] DIFF_60_HI = 16'd45;
  localparam logic [StampW-1:0] DIFF_50_LO = 16'd45;
  localparam logic [StampW-1:0] DIFF_50_HI = 16'd55;

  // Calibration pairs: ADC code and reading at the low and high points.
  localparam logic signed [CalW-1:0] AD_LO_50  = 12'sd211;
  localparam logic signed [CalW-1:0] SLOPE_50  = 12'sd1497;  // 2407 - 910
  localparam logic signed [ProdW-1:0] SPAN_50  = 24'sd365;   // 576 - 211
  localparam logic signed [ProdW-1:0] V_LO_50  = 24'sd910;
  localparam logic signed [CalW-1:0] AD_LO_60  = 12'sd216;
  localparam logic signed [CalW-1:0] SLOPE_60  = 12'sd1501;  // 2403 - 902
  localparam logic signed [ProdW-1:0] SPAN_60  = 24'sd373;   // 589 - 216
  localparam logic signed [ProdW-1:0] V_LO_60  = 24'sd902;

  localparam logic [Volt10W-1:0] VOLT_SCALE = 13'd10;

  // Reciprocals for the constant divides. The shift is the operand width plus
  // the bits of the divisor, which keeps the quotient exact over the whole range.
  localparam int SpanShift  = 30;
  localparam int SpanRecipW = 22;
  localparam logic [SpanRecipW-1:0] SPAN_RECIP_50 =
    SpanRecipW'(((64'd1 << SpanShift) + 64'(SPAN_50) - 64'd1) / 64'(SPAN_50));
  localparam logic [SpanRecipW-1:0] SPAN_RECIP_60 =
    SpanRecipW'(((64'd1 << SpanShift) + 64'(SPAN_60) - 64'd1) / 64'(SPAN_60));

  localparam int VoltShift  = 17;
  localparam int VoltRecipW = 14;
  localparam logic [VoltRecipW-1:0] VOLT_RECIP =
    VoltRecipW'(((64'd1 << VoltShift) + 64'(VOLT_SCALE) - 64'd1) / 64'(VOLT_SCALE));

  localparam logic [PeriodW-1:0] PERIOD_50 = 7'd100;
  localparam logic [PeriodW-1:0] PERIOD_60 = 7'd83;

  // Stage enables of the conversion pipeline.
  typedef struct packed {
    logic mul;
    logic scale;
    logic out;
  } pipe_en_t;

  function automatic logic [PeriodW-1:0] period_of(freq_e f);
    logic [PeriodW-1:0] p;
    case (f)
      FREQ_50: p = PERIOD_50;
      FREQ_60: p = PERIOD_60;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

[sv/mvfm_convert.sv]
// ----------------------------------------------------------------------------
// mvfm_convert
// Three-stage linear calibration of an averaged ADC code into a reading.
// ----------------------------------------------------------------------------
module mvfm_convert (
  input  logic                       clk_i,
  input  mvfm_pkg::pipe_en_t         en_i,
  input  logic [9:0]                 avg_i,
  input  logic                       use_50_i,
  output logic [8:0]                 voltage_o
);
  import mvfm_pkg::*;

  logic signed [CalW-1:0]            diff;
  logic                              neg_d, neg_q;
  logic [CalW-1:0]                   diff_mag;
  logic [MagW-1:0]                   mag_d, mag_q;
  logic                              sel_q;
  logic [MagW+SpanRecipW-1:0]        quot_prod;
  logic signed [ProdW-1:0]           quot, lin;
  logic [Volt10W-1:0]                volt10_d, volt10_q;
  logic [Volt10W+VoltRecipW-1:0]     volt_prod;
  logic [VoltW-1:0]                  volt_q;

  // Offset from the low calibration point, times the reading span. The sign is
  // kept apart so that the divide works on the magnitude.
  always_comb begin
    diff     = $signed({2'b00, avg_i}) - (use_50_i ? AD_LO_50 : AD_LO_60);
    neg_d    = diff[CalW-1];
    diff_mag = neg_d ? $unsigned(-diff) : $unsigned(diff);
    mag_d    = MagW'(diff_mag) * MagW'($unsigned(use_50_i ? SLOPE_50 : SLOPE_60));
  end

  // Dividing the magnitude and restoring the sign truncates toward zero, as the
  // calibration expects.
  always_comb begin
    quot_prod = (MagW+SpanRecipW)'(mag_q) *
                (MagW+SpanRecipW)'(sel_q ? SPAN_RECIP_50 : SPAN_RECIP_60);
    quot      = $signed(ProdW'(quot_prod >> SpanShift));
    lin       = (sel_q ? V_LO_50 : V_LO_60) + (neg_q ? -quot : quot);
    volt10_d  = (lin < 0) ? '0 : Volt10W'(lin);
    volt_prod = (Volt10W+VoltRecipW)'(volt10_q) * (Volt10W+VoltRecipW)'(VOLT_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      sel_q <= use_50_i;
    end
    if (en_i.scale) begin
      volt10_q <= volt10_d;
    end
    if (en_i.out) begin
      volt_q <= VoltW'(volt_prod >> VoltShift);
    end
  end

  assign voltage_o = volt_q;

endmodule

[sv/mains_voltage_frequency_monitor.sv]
// ----------------------------------------------------------------------------
// mains_voltage_frequency_monitor
// Window-minimum line frequency detection and averaged, calibrated voltage.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle, set by the state update at input, while no stall
//   at the output has filled the stages. Pipeline: state update and average into stage
//   one, then multiply, span divide and divide by ten, each registered in turn.
// Results wait in the output register without blocking input while stages are free.
// Reset clears all frequency and averaging state and empties the pipeline.
module mains_voltage_frequency_monitor #(
  parameter int AVERAGE_COUNT = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            mode_i,
  input  logic [9:0]      sample_i,
  input  logic            window_end_i,
  input  logic [15:0]     tick_stamp_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mvfm_pkg::kind_e result_kind_o,
  output logic [8:0]      voltage_o,
  output mvfm_pkg::freq_e line_frequency_o,
  output logic [6:0]      period_value_o
);
  import mvfm_pkg::*;

  localparam int CntW = $clog2(AVERAGE_COUNT + 1);

  // The divide by the sample count is a reciprocal multiply, exact for any sum.
  localparam int AvgShift  = SumW + $clog2(AVERAGE_COUNT);
  localparam int AvgRecipW = SumW + 1;
  localparam logic [AvgRecipW-1:0] AvgRecip =
    AvgRecipW'(((64'd1 << AvgShift) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));

  // Persistent state.
  freq_e               det_freq_q, det_freq_d;
  logic                second_q, second_d;
  logic                have_min_q, have_min_d;
  logic [SampleW-1:0]  min_sample_q, min_sample_d;
  logic [StampW-1:0]   min_stamp_q, min_stamp_d;
  logic [StampW-1:0]   first_stamp_q, first_stamp_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [CntW-1:0]     count_q, count_d;

  // Pipeline control and side data.
  logic                accept, emit;
  logic                adv1, adv2, adv3, adv_out;
  logic                v1_q, v2_q, v3_q, vo_q;
  kind_e               kind1_d, kind1_q, kind2_q, kind3_q, kind_o_q;
  freq_e               freq1_d, freq1_q, freq2_q, freq3_q, freq_o_q;
  logic [SampleW-1:0]  avg1_d, avg1_q;
  logic [SumW-1:0]     sum_next;
  logic [SumW+AvgRecipW-1:0] avg_prod;
  logic [CntW-1:0]     count_next;
  logic [StampW-1:0]   got, diff;
  pipe_en_t            pipe_en;
  logic [VoltW-1:0]    conv_volt;

  assign adv_out    = !vo_q || out_ready_i;
  assign adv3       = !v3_q || adv_out;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign accept     = in_valid_i && adv1;

  always_comb begin
    sum_next   = sum_q + SumW'(sample_i);
    avg_prod   = (SumW+AvgRecipW)'(sum_next) * (SumW+AvgRecipW)'(AvgRecip);
    count_next = count_q + CntW'(1);
    got        = have_min_q ? min_stamp_q : '0;
    diff       = (first_stamp_q > got) ? (first_stamp_q - got) : (got - first_stamp_q);

    det_freq_d    = det_freq_q;
    second_d      = second_q;
    have_min_d    = have_min_q;
    min_sample_d  = min_sample_q;
    min_stamp_d   = min_stamp_q;
    first_stamp_d = first_stamp_q;
    sum_d         = sum_q;
    count_d       = count_q;
    emit          = 1'b0;
    kind1_d       = KIND_VOLTAGE;
    freq1_d       = det_freq_q;
    avg1_d        = '0;

    if (accept) begin
      if (mode_i) begin
        sum_d   = sum_next;
        count_d = count_next;
        if (32'(count_next) >= AVERAGE_COUNT) begin
          avg1_d  = SampleW'(avg_prod >> AvgShift);
          sum_d   = '0;
          count_d = '0;
          emit    = 1'b1;
        end
      end else if (!window_end_i) begin
        // A later sample equal to the minimum keeps the earlier stamp.
        if (!have_min_q || sample_i < min_sample_q) begin
          min_sample_d = sample_i;
          min_stamp_d  = tick_stamp_i;
          have_min_d   = 1'b1;
        end
      end else begin
        have_min_d   = 1'b0;
        min_sample_d = '0;
        if (!second_q) begin
          first_stamp_d = got;
          second_d      = 1'b1;
        end else begin
          second_d = 1'b0;
          emit     = 1'b1;
          if (diff > DIFF_60_LO && diff < DIFF_60_HI) begin
            det_freq_d = FREQ_60;
            kind1_d    = KIND_FREQ;
            freq1_d    = FREQ_60;
          end else if (diff > DIFF_50_LO && diff < DIFF_50_HI) begin
            det_freq_d = FREQ_50;
            kind1_d    = KIND_FREQ;
            freq1_d    = FREQ_50;
          end else begin
            kind1_d = KIND_RETRY;
            freq1_d = FREQ_UNKNOWN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_freq_q    <= FREQ_UNKNOWN;
      second_q      <= 1'b0;
      have_min_q    <= 1'b0;
      min_sample_q  <= '0;
      min_stamp_q   <= '0;
      first_stamp_q <= '0;
      sum_q         <= '0;
      count_q       <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      vo_q          <= 1'b0;
    end else begin
      det_freq_q    <= det_freq_d;
      second_q      <= second_d;
      have_min_q    <= have_min_d;
      min_sample_q  <= min_sample_d;
      min_stamp_q   <= min_stamp_d;
      first_stamp_q <= first_stamp_d;
      sum_q         <= sum_d;
      count_q       <= count_d;
      if (adv1) begin
        v1_q <= emit;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv_out) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      kind1_q <= kind1_d;
      freq1_q <= freq1_d;
      avg1_q  <= avg1_d;
    end
    if (adv2) begin
      kind2_q <= kind1_q;
      freq2_q <= freq1_q;
    end
    if (adv3) begin
      kind3_q <= kind2_q;
      freq3_q <= freq2_q;
    end
    if (adv_out) begin
      kind_o_q <= kind3_q;
      freq_o_q <= freq3_q;
    end
  end

  assign pipe_en.mul   = adv2;
  assign pipe_en.scale = adv3;
  assign pipe_en.out   = adv_out;

  mvfm_convert u_convert (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .avg_i     (avg1_q),
    .use_50_i  (freq1_q == FREQ_50),
    .voltage_o (conv_volt)
  );

  assign out_valid_o      = vo_q;
  assign result_kind_o    = kind_o_q;
  assign line_frequency_o = freq_o_q;
  assign period_value_o   = period_of(freq_o_q);
  assign voltage_o        = (kind_o_q == KIND_VOLTAGE) ? conv_volt : '0;

endmodule

[sv/mvfm_checker.sv]
// ----------------------------------------------------------------------------
// mvfm_checker
// Port-level checks of the mains monitor's result words.
// ----------------------------------------------------------------------------
`include "mains_voltage_frequency_monitor_macros.svh"

module mvfm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mvfm_pkg::kind_e result_kind_o,
  input logic [8:0]      voltage_o,
  input mvfm_pkg::freq_e line_frequency_o,
  input logic [6:0]      period_value_o
);
  import mvfm_pkg::*;

  // A stalled result word keeps its contents.
  `MVFM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_kind_o) && $stable(voltage_o) && $stable(line_frequency_o))

  // A retry carries no frequency.
  `MVFM_ASSERT_SAME(a_retry_empty, clk_i, rst_ni, out_valid_o && result_kind_o == KIND_RETRY, line_frequency_o == FREQ_UNKNOWN && period_value_o == '0)

  // A frequency word names a known frequency.
  `MVFM_ASSERT_SAME(a_freq_known, clk_i, rst_ni, out_valid_o && result_kind_o == KIND_FREQ, line_frequency_o == FREQ_50 || line_frequency_o == FREQ_60)

  // Only voltage words carry a reading.
  `MVFM_ASSERT_SAME(a_volt_only, clk_i, rst_ni, out_valid_o && result_kind_o != KIND_VOLTAGE, voltage_o == '0)

  // The period always matches the frequency code.
  `MVFM_ASSERT_SAME(a_period_match, clk_i, rst_ni, out_valid_o, (line_frequency_o == FREQ_50 && period_value_o == PERIOD_50) || (line_frequency_o == FREQ_60 && period_value_o == PERIOD_60) || (line_frequency_o == FREQ_UNKNOWN && period_value_o == '0))

endmodule

bind mains_voltage_frequency_monitor mvfm_checker u_mvfm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_kind_o    (result_kind_o),
  .voltage_o        (voltage_o),
  .line_frequency_o (line_frequency_o),
  .period_value_o   (period_value_o)
);
